@@ rtl/core/pidc_pkg.sv @@
package pidc_pkg;

    localparam int NUM_MOTORS_DEF         = 2;
    localparam int GAIN_FRACTION_BITS_DEF = 12;

    localparam int ERR_W  = 17;
    localparam int SUM_W  = 18;
    localparam int DIFF_W = 18;
    localparam int PROD_W = 35;
    localparam int ACC_W  = 37;

    localparam logic [15:0] KP_RESET   = 16'd9011;
    localparam logic [15:0] KI_RESET   = 16'd53;
    localparam logic [15:0] KD_RESET   = 16'd205;
    localparam logic [15:0] ILIM_RESET = 16'd1000;
    localparam logic [14:0] DLIM_RESET = 15'd2500;

    typedef enum logic [2:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_ILIM = 3'd3,
        REG_DLIM = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [15:0] ilim;
        logic [14:0] dlim;
    } cfg_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic signed [ERR_W-1:0] err;
    } state_entry_t;

    typedef struct packed {
        logic                     valid;
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
    } terms_t;

endpackage

@@ rtl/core/pidc_regs.sv @@
module pidc_regs
    import pidc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp   <= KP_RESET;
            cfg_reg.ki   <= KI_RESET;
            cfg_reg.kd   <= KD_RESET;
            cfg_reg.ilim <= ILIM_RESET;
            cfg_reg.dlim <= DLIM_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_KP:   cfg_reg.kp   <= pwdata[15:0];
                REG_KI:   cfg_reg.ki   <= pwdata[15:0];
                REG_KD:   cfg_reg.kd   <= pwdata[15:0];
                REG_ILIM: cfg_reg.ilim <= pwdata[15:0];
                REG_DLIM: cfg_reg.dlim <= pwdata[14:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_KP:   prdata = {16'd0, cfg_reg.kp};
            REG_KI:   prdata = {16'd0, cfg_reg.ki};
            REG_KD:   prdata = {16'd0, cfg_reg.kd};
            REG_ILIM: prdata = {16'd0, cfg_reg.ilim};
            REG_DLIM: prdata = {17'd0, cfg_reg.dlim};
            default:  prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/core/pidc_state.sv @@
module pidc_state
    import pidc_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               accept,
    input  logic               motor_index,
    input  logic signed [15:0] measured_position,
    input  logic signed [15:0] target_position,
    input  logic [15:0]        ilim,
    output terms_t             terms
);

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    state_entry_t mem [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] valid_reg;

    logic [IDX_W-1:0]        idx_next;
    logic signed [ERR_W-1:0] err_next;

    logic                    s1_valid_reg;
    logic [IDX_W-1:0]        s1_idx_reg;
    logic signed [ERR_W-1:0] s1_err_reg;
    state_entry_t            rd_data_reg;
    logic                    rd_valid_reg;

    // Last entry written, kept for the transfer that read the memory at that same edge.
    logic                    wb_valid_reg;
    logic [IDX_W-1:0]        wb_idx_reg;
    state_entry_t            wb_data_reg;

    state_entry_t             cur;
    logic signed [SUM_W:0]    sum_raw;
    logic signed [SUM_W:0]    lim;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [DIFF_W-1:0] diff_next;
    logic                     wr_en;
    logic                     terms_valid_reg;
    logic signed [ERR_W-1:0]  terms_err_reg;
    logic signed [SUM_W-1:0]  terms_sum_reg;
    logic signed [DIFF_W-1:0] terms_diff_reg;

    always_comb
    begin
        if ({31'd0, motor_index} >= NUM_MOTORS)
            idx_next = IDX_W'(NUM_MOTORS - 1);
        else
            idx_next = IDX_W'(motor_index);
        err_next = {target_position[15], target_position}
                 - {measured_position[15], measured_position};
    end

    always_comb
    begin
        if (wb_valid_reg && (wb_idx_reg == s1_idx_reg))
            cur = wb_data_reg;
        else if (rd_valid_reg)
            cur = rd_data_reg;
        else
            cur = '0;

        sum_raw = (SUM_W+1)'(cur.sum) + (SUM_W+1)'(s1_err_reg);
        lim     = $signed({3'd0, ilim});
        if (sum_raw > lim)
            sum_next = SUM_W'(lim);
        else if (sum_raw < -lim)
            sum_next = SUM_W'(-lim);
        else
            sum_next = SUM_W'(sum_raw);
        diff_next = DIFF_W'(s1_err_reg) - DIFF_W'(cur.err);
    end

    assign wr_en = s1_valid_reg && adv;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_idx_reg] <= '{sum: sum_next, err: s1_err_reg};
        if (accept)
            rd_data_reg <= mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            wb_valid_reg    <= 1'b0;
            terms_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (wr_en)
                valid_reg[s1_idx_reg] <= 1'b1;
            s1_valid_reg    <= accept;
            wb_valid_reg    <= s1_valid_reg;
            terms_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= idx_next;
            s1_err_reg   <= err_next;
            rd_valid_reg <= valid_reg[idx_next];
        end
        if (adv)
        begin
            wb_idx_reg     <= s1_idx_reg;
            wb_data_reg    <= '{sum: sum_next, err: s1_err_reg};
            terms_err_reg  <= s1_err_reg;
            terms_sum_reg  <= sum_next;
            terms_diff_reg <= diff_next;
        end
    end

    assign terms = '{valid: terms_valid_reg, err: terms_err_reg, sum: terms_sum_reg,
                     diff: terms_diff_reg};

endmodule

@@ rtl/core/pidc_datapath.sv @@
module pidc_datapath
    import pidc_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  terms_t             terms,
    input  cfg_t               cfg,
    output logic               drive_valid,
    output logic signed [15:0] drive_value
);

    logic signed [PROD_W-1:0] p_next, i_next, d_next;
    logic signed [PROD_W-1:0] p_reg, i_reg, d_reg;
    logic                     prod_valid_reg;

    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     acc_valid_reg;

    logic [ACC_W-1:0]         mag_abs;
    logic [ACC_W-1:0]         mag_next;
    logic [ACC_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic                     mag_valid_reg;

    logic [14:0]              clamped;
    logic signed [15:0]       drive_next;
    logic signed [15:0]       drive_value_reg;
    logic                     drive_valid_reg;

    assign p_next = PROD_W'($signed({1'b0, cfg.kp})) * PROD_W'(terms.err);
    assign i_next = PROD_W'($signed({1'b0, cfg.ki})) * PROD_W'(terms.sum);
    assign d_next = PROD_W'($signed({1'b0, cfg.kd})) * PROD_W'(terms.diff);

    assign acc_next = ACC_W'(p_reg) + ACC_W'(i_reg) + ACC_W'(d_reg);

    // Truncation toward zero: scale the magnitude, then restore the sign.
    always_comb
    begin
        if (acc_reg[ACC_W-1])
            mag_abs = ACC_W'(-acc_reg);
        else
            mag_abs = ACC_W'(acc_reg);
        mag_next = mag_abs >> GAIN_FRACTION_BITS;
    end

    always_comb
    begin
        if (mag_reg > ACC_W'(cfg.dlim))
            clamped = cfg.dlim;
        else
            clamped = mag_reg[14:0];
        if (neg_reg)
            drive_next = -$signed({1'b0, clamped});
        else
            drive_next = $signed({1'b0, clamped});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            acc_valid_reg   <= 1'b0;
            mag_valid_reg   <= 1'b0;
            drive_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg  <= terms.valid;
            acc_valid_reg   <= prod_valid_reg;
            mag_valid_reg   <= acc_valid_reg;
            drive_valid_reg <= mag_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg           <= p_next;
            i_reg           <= i_next;
            d_reg           <= d_next;
            acc_reg         <= acc_next;
            mag_reg         <= mag_next;
            neg_reg         <= acc_reg[ACC_W-1];
            drive_value_reg <= drive_next;
        end
    end

    assign drive_valid = drive_valid_reg;
    assign drive_value = drive_value_reg;

endmodule

@@ rtl/core/positional_pid_controller.sv @@
// Channel   Handshake                   Payload
// sample    sample_valid/sample_ready   motor_index, measured_position, target_position
// drive     drive_valid/drive_ready     drive_value
// config    APB psel/penable/pready     paddr, pwdata, prdata
//
// One sample per cycle is taken unless stalled, via the s1, terms, product, accumulator,
// magnitude and drive registers. The per-motor state memory is read at accept and
// written back as the sample leaves s1; the written entry is forwarded to a following
// sample of the same motor. Reset clears the per-entry valid bits at once, so no clearing
// pass is needed. A stalled drive output holds the whole pipeline and sample_ready drops.
module positional_pid_controller
    import pidc_pkg::*;
#(
    parameter int NUM_MOTORS         = NUM_MOTORS_DEF,
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               sample_valid,
    output logic               sample_ready,
    input  logic               motor_index,
    input  logic signed [15:0] measured_position,
    input  logic signed [15:0] target_position,

    output logic               drive_valid,
    input  logic               drive_ready,
    output logic signed [15:0] drive_value,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t   cfg;
    terms_t terms;
    logic   adv;
    logic   accept;

    assign adv          = !drive_valid || drive_ready;
    assign sample_ready = adv;
    assign accept       = sample_valid && adv;

    pidc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidc_state #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_state (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .accept            (accept),
        .motor_index       (motor_index),
        .measured_position (measured_position),
        .target_position   (target_position),
        .ilim              (cfg.ilim),
        .terms             (terms)
    );

    pidc_datapath #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .terms       (terms),
        .cfg         (cfg),
        .drive_valid (drive_valid),
        .drive_value (drive_value)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import pidc_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 240;

    logic               clk               = 1'b0;
    logic               rst_n             = 1'b0;
    logic               sample_valid      = 1'b0;
    logic               sample_ready;
    logic               motor_index       = 1'b0;
    logic signed [15:0] measured_position = '0;
    logic signed [15:0] target_position   = '0;
    logic               drive_valid;
    logic               drive_ready       = 1'b0;
    logic signed [15:0] drive_value;
    logic               psel              = 1'b0;
    logic               penable           = 1'b0;
    logic               pwrite            = 1'b0;
    logic [4:0]         paddr             = '0;
    logic [31:0]        pwdata            = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow of the register file and of the per-motor controller state.
    logic [15:0] kp_gain     = KP_RESET;
    logic [15:0] ki_gain     = KI_RESET;
    logic [15:0] kd_gain     = KD_RESET;
    logic [15:0] sum_limit   = ILIM_RESET;
    logic [14:0] drive_limit = DLIM_RESET;
    int          error_sum_shadow [2] = '{0, 0};
    int          last_error_shadow[2] = '{0, 0};

    // Stimulus: a crude plant position chasing a target per motor, blind to the drive output.
    int plant_pos   [2] = '{0, 0};
    int plant_target[2] = '{0, 0};

    logic signed [15:0] expected_drive[$];
    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_gap_pct     = 0;
    int rx_stall_pct   = 0;
    int rx_hold_cycles = 0;

    positional_pid_controller i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .motor_index       (motor_index),
        .measured_position (measured_position),
        .target_position   (target_position),
        .drive_valid       (drive_valid),
        .drive_ready       (drive_ready),
        .drive_value       (drive_value),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("positional_pid_controller: mismatch");
            $finish;
        end
    end

    function automatic logic signed [15:0] pid_predict_drive(input logic m,
                                                             input logic signed [15:0] pos,
                                                             input logic signed [15:0] tgt);
        int     err;
        int     sum;
        int     diff;
        int     lim;
        longint acc;
        longint mag;
        err  = int'(tgt) - int'(pos);
        lim  = int'(sum_limit);
        sum  = error_sum_shadow[m] + err;
        if (sum > lim)
            sum = lim;
        else if (sum < -lim)
            sum = -lim;
        diff = err - last_error_shadow[m];
        acc  = longint'(kp_gain) * err + longint'(ki_gain) * sum + longint'(kd_gain) * diff;
        // Truncation toward zero: shift the magnitude, then restore the sign.
        mag  = (acc < 0) ? -acc : acc;
        mag  = mag >> GAIN_FRACTION_BITS_DEF;
        if (mag > longint'(drive_limit))
            mag = longint'(drive_limit);
        error_sum_shadow[m]  = sum;
        last_error_shadow[m] = err;
        return (acc < 0) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("ERROR at cycle %0d: %s expected %0d, got %0d", cycle_count, what, expected,
                 got);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && drive_valid && drive_ready)
        begin
            if (expected_drive.size() == 0)
                report_mismatch("unexpected drive transfer, drive_value", 0, drive_value);
            else if (drive_value !== expected_drive[0])
                report_mismatch("drive_value", expected_drive.pop_front(), drive_value);
            else
                void'(expected_drive.pop_front());
        end
    end

    // Drive-side receiver: random stalls, plus a long hold-off on request.
    initial
    begin : drive_receiver
        int stall;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                drive_ready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
                drive_ready <= 1'b1;
            end
            else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                stall = $urandom_range(1, 18);
                drive_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                drive_ready <= 1'b1;
            end
            else
                drive_ready <= 1'b1;
        end
    end

    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_KP:   kp_gain     = value[15:0];
            REG_KI:   ki_gain     = value[15:0];
            REG_KD:   kd_gain     = value[15:0];
            REG_ILIM: sum_limit   = value[15:0];
            REG_DLIM: drive_limit = value[14:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] ilim,
                                input logic [31:0] dlim);
        write_register(REG_KP, kp);
        write_register(REG_KI, ki);
        write_register(REG_KD, kd);
        write_register(REG_ILIM, ilim);
        write_register(REG_DLIM, dlim);
    endtask

    // Drops valid, waits for every outstanding drive value, then lets the pipe settle.
    task automatic drain_pipeline();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Valid stays high after the transfer; the next call or a drain changes it.
    task automatic send_sample(input logic m, input logic signed [15:0] pos,
                               input logic signed [15:0] tgt);
        int gap;
        @(negedge clk);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            gap = $urandom_range(1, 18);
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid      <= 1'b1;
        motor_index       <= m;
        measured_position <= pos;
        target_position   <= tgt;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        expected_drive.push_back(pid_predict_drive(m, pos, tgt));
    endtask

    task automatic send_random_sample();
        logic m;
        int   step;
        m = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            send_sample(m, 16'($urandom), 16'($urandom));
        else
        begin
            if ($urandom_range(0, 31) == 0)
                plant_target[m] = int'($urandom_range(0, 65535)) - 32768;
            step = (plant_target[m] - plant_pos[m]) / 8 + int'($urandom_range(0, 64)) - 32;
            plant_pos[m] = plant_pos[m] + step;
            if (plant_pos[m] > 32767)
                plant_pos[m] = 32767;
            else if (plant_pos[m] < -32768)
                plant_pos[m] = -32768;
            send_sample(m, 16'(plant_pos[m]), 16'(plant_target[m]));
        end
    endtask

    task automatic random_gain(output logic [31:0] value);
        value = $urandom;
        if ($urandom_range(0, 3) != 0)
            value = (value & 32'hFFFF_0000) | $urandom_range(0, 16384);
    endtask

    task automatic test_reset_values();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        send_sample(1'b0, 16'sd0, 16'sd0);
        send_sample(1'b1, 16'sd0, 16'sd0);
        send_sample(1'b0, -16'sd32768, 16'sd32767);
        send_sample(1'b0, 16'sd32767, -16'sd32768);
        send_sample(1'b1, 16'h5555, 16'hAAAA);
        send_sample(1'b1, 16'hAAAA, 16'h5555);
        send_sample(1'b0, 16'sd100, -16'sd100);
        send_sample(1'b1, -16'sd1, 16'sd1);
        drain_pipeline();
    endtask

    task automatic test_extreme_gains();
        write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(1'b0, -16'sd32768, 16'sd32767);
        send_sample(1'b0, -16'sd32768, 16'sd32767);
        send_sample(1'b1, 16'sd32767, -16'sd32768);
        send_sample(1'b1, 16'sd32767, -16'sd32768);
        send_sample(1'b0, 16'sd0, 16'sd0);
        drain_pipeline();
    endtask

    task automatic test_zero_limits();
        // Zero drive limit forces zero output; zero integral limit pins the sum at zero.
        write_config(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h0, 32'h0);
        send_sample(1'b0, -16'sd32768, 16'sd32767);
        send_sample(1'b1, 16'sd1234, -16'sd4321);
        send_sample(1'b0, 16'sd5, 16'sd5);
        drain_pipeline();
        write_register(REG_DLIM, 32'h7FFF);
        send_sample(1'b0, 16'sd0, 16'sd300);
        send_sample(1'b1, 16'sd300, 16'sd0);
        send_sample(1'b0, 16'sd0, 16'sd300);
        drain_pipeline();
    endtask

    task automatic test_lowered_limit();
        // The stored sum is only clamped to a lowered limit on that motor's next update.
        write_config(KP_RESET, KI_RESET, KD_RESET, 32'hFFFF, 32'h7FFF);
        send_sample(1'b0, -16'sd32768, 16'sd32767);
        send_sample(1'b0, -16'sd32768, 16'sd32767);
        drain_pipeline();
        write_register(REG_ILIM, 32'd50);
        send_sample(1'b1, 16'sd0, 16'sd10);
        send_sample(1'b0, 16'sd0, 16'sd10);
        drain_pipeline();
    endtask

    task automatic test_random_phases();
        logic [31:0] kp;
        logic [31:0] ki;
        logic [31:0] kd;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: write_config(KP_RESET, KI_RESET, KD_RESET, ILIM_RESET, DLIM_RESET);
                1: write_config(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h7FFF);
                2: write_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
                default:
                begin
                    random_gain(kp);
                    random_gain(ki);
                    random_gain(kd);
                    write_config(kp, ki, kd, $urandom, $urandom);
                end
            endcase
            tx_gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(5, 40);
            rx_stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 40);
            repeat (PHASE_ITEMS) send_random_sample();
            drain_pipeline();
        end
    endtask

    task automatic test_backpressure();
        write_config(KP_RESET, 32'd400, KD_RESET, 32'd20000, 32'd30000);
        tx_gap_pct     = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 80;
        repeat (40) send_random_sample();
        drain_pipeline();
        repeat (20) send_random_sample();
        drain_pipeline();
    endtask

    task automatic test_streaming();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        repeat (200) send_random_sample();
        drain_pipeline();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_reset_values();
        test_extreme_gains();
        test_zero_limits();
        test_lowered_limit();
        test_random_phases();
        test_backpressure();
        test_streaming();

        if (mismatch_count == 0)
            $display("positional_pid_controller: match");
        else
            $display("positional_pid_controller: mismatch");
        $finish;
    end

endmodule
